>>> hw/rtl/page_frame_buffer_rasterizer_defines.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef PAGE_FRAME_BUFFER_RASTERIZER_DEFINES_SVH
`define PAGE_FRAME_BUFFER_RASTERIZER_DEFINES_SVH
// implication checked on every rising edge outside reset
`define PFB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the next cycle
`define PFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/pfb_pkg.sv
// Package for the page frame buffer rasterizer: constants, action codes, states, return codes.
// No dependencies.
package pfb_pkg;
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 4;

    typedef enum logic [2:0] {
        ACT_POINT  = 3'd0,
        ACT_FILL   = 3'd1,
        ACT_LINE   = 3'd2,
        ACT_RECT   = 3'd3,
        ACT_CIRCLE = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_LINE_SETUP,
        ST_LINE,
        ST_CIRCLE,
        ST_READ,
        ST_RMW,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RET_FILL,
        RET_LINE,
        RET_CIRCLE,
        RET_NONE
    } ret_t;
endpackage

>>> hw/rtl/pfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> hw/rtl/page_frame_buffer_rasterizer.sv
// Top level of the page frame buffer rasterizer: command sequencer and pixel stepping.
// Depends on pfb_pkg and pfb_ram.
//
// Each command word draws into a COLUMNS x (PAGES*8) monochrome frame buffer held in
// one RAM of PAGES*COLUMNS bytes, one read-modify-write per pixel (step, read, write
// back); a pixel is read only after the previous one is written. A fill steps over
// the clipped box, a line over dist+2 pixels with dist the larger of |dx| and |dy|,
// a rectangle over its four lines, a circle over the eight octant points of each
// step of its loop; a rejected line draws nothing. Off-screen points still pass
// through the read and write-back steps, with the write held off. The result word
// leaves as s_tready returns; a finished command waits in its output state while an
// earlier word is still not taken. After reset the RAM is cleared one byte a cycle
// until all PAGES*COLUMNS bytes are zero, during which s_tready stays low. One result
// word leaves per command: the read byte, else zero.
module page_frame_buffer_rasterizer
    import pfb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[2:0], x_a[10:3], y_a[18:11], x_b[26:19], y_b[34:27], radius[42:35],
    // read_page[44:43], dot[45], zero fill [47:46]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata
);
    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = PAGES * 8;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]    act_reg, act_next;
    logic [7:0]    xa_reg, xa_next, ya_reg, ya_next, xb_reg, xb_next, yb_reg, yb_next;
    logic [1:0]    pg_reg, pg_next;
    logic          dot_reg, dot_next;
    logic [7:0]    res_reg, res_next;
    logic [7:0]    out_reg, out_next;
    logic          ov_reg, ov_next;

    // pixel under read-modify-write
    logic [7:0]    px_reg, px_next, py_reg, py_next;

    // fill / line / circle iterators
    logic [7:0]    fx_reg, fx_next, fy_reg, fy_next, fx2_reg, fx2_next, fy2_reg, fy2_next;
    logic [1:0]    seg_reg, seg_next;
    logic [7:0]    lx1_reg, lx1_next, ly1_reg, ly1_next, lx2_reg, lx2_next, ly2_reg, ly2_next;
    logic [8:0]    dx_reg, dx_next, dy_reg, dy_next, dist_reg, dist_next;
    logic [9:0]    ex_reg, ex_next, ey_reg, ey_next;
    logic [9:0]    cnt_reg, cnt_next;
    logic          sxn_reg, sxn_next, sxz_reg, sxz_next, syn_reg, syn_next, syz_reg, syz_next;
    logic [8:0]    ca_reg, ca_next;
    logic [9:0]    cb_reg, cb_next;
    logic [11:0]   cd_reg, cd_next;
    logic [2:0]    oct_reg, oct_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    pfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic logic [AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
        logic [AW:0] pg;
        pg = (AW+1)'(PAGES - 1) - (AW+1)'(y[7:3]);
        return AW'(pg * (AW+1)'(COLUMNS) + (AW+1)'(x));
    endfunction

    logic          on_screen;
    logic [7:0]    mask;
    logic [AW-1:0] paddr;
    logic [7:0]    ox, oy;
    logic [7:0]    ua, ub;
    logic [9:0]    ex_s, ey_s;
    logic          rej;
    logic [8:0]    ddx, ddy;
    logic [7:0]    merged;

    assign on_screen = (32'(px_reg) < COLUMNS) && (32'(py_reg) < ROWS);
    assign mask      = 8'h80 >> py_reg[2:0];
    assign paddr     = pix_addr(px_reg, py_reg);
    assign merged    = dot_reg ? (rd_data | mask) : (rd_data & ~mask);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = out_reg;

    always_comb begin
        ua = ca_reg[7:0];
        ub = cb_reg[7:0];
        case (oct_reg)
            3'd0: begin ox = xa_reg + ua; oy = ya_reg - ub; end
            3'd1: begin ox = xa_reg + ub; oy = ya_reg - ua; end
            3'd2: begin ox = xa_reg + ub; oy = ya_reg + ua; end
            3'd3: begin ox = xa_reg + ua; oy = ya_reg + ub; end
            3'd4: begin ox = xa_reg - ua; oy = ya_reg + ub; end
            3'd5: begin ox = xa_reg - ub; oy = ya_reg + ua; end
            3'd6: begin ox = xa_reg - ua; oy = ya_reg - ub; end
            default: begin ox = xa_reg - ub; oy = ya_reg - ua; end
        endcase
    end

    always_comb begin
        state_next = state_reg;  ret_next = ret_reg;   clr_next = clr_reg;
        act_next = act_reg;      xa_next = xa_reg;     ya_next = ya_reg;
        xb_next = xb_reg;        yb_next = yb_reg;     pg_next = pg_reg;
        dot_next = dot_reg;      out_next = out_reg;   ov_next = ov_reg;
        res_next = res_reg;
        px_next = px_reg;        py_next = py_reg;     fx_next = fx_reg;
        fy_next = fy_reg;        fx2_next = fx2_reg;   fy2_next = fy2_reg;
        seg_next = seg_reg;      lx1_next = lx1_reg;   ly1_next = ly1_reg;
        lx2_next = lx2_reg;      ly2_next = ly2_reg;   dx_next = dx_reg;
        dy_next = dy_reg;        dist_next = dist_reg; ex_next = ex_reg;
        ey_next = ey_reg;        cnt_next = cnt_reg;   sxn_next = sxn_reg;
        sxz_next = sxz_reg;      syn_next = syn_reg;   syz_next = syz_reg;
        ca_next = ca_reg;        cb_next = cb_reg;     cd_next = cd_reg;
        oct_next = oct_reg;
        wr_en = 1'b0;  wr_addr = paddr;  wr_data = merged;  rd_addr = paddr;
        ex_s = ex_reg + {1'b0, dx_reg};
        ey_s = ey_reg + {1'b0, dy_reg};
        rej = (32'(lx1_reg) > COLUMNS) || (32'(lx2_reg) > COLUMNS)
           || (32'(ly1_reg) > ROWS) || (32'(ly2_reg) > ROWS);
        ddx = (lx2_reg >= lx1_reg) ? 9'(lx2_reg - lx1_reg) : 9'(lx1_reg - lx2_reg);
        ddy = (ly2_reg >= ly1_reg) ? 9'(ly2_reg - ly1_reg) : 9'(ly1_reg - ly2_reg);

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = clr_reg;
                wr_data = 8'h00;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next = s_tdata[2:0];
                    xa_next = s_tdata[10:3];
                    ya_next = s_tdata[18:11];
                    xb_next = s_tdata[26:19];
                    yb_next = s_tdata[34:27];
                    pg_next = s_tdata[44:43];
                    dot_next = s_tdata[45];
                    res_next = 8'h00;
                    ca_next = 9'd0;
                    cb_next = {2'b00, s_tdata[42:35]};
                    cd_next = 12'd3 - {3'b000, s_tdata[42:35], 1'b0};
                    oct_next = 3'd0;
                    seg_next = 2'd0;
                    fx_next = s_tdata[10:3];
                    fy_next = s_tdata[18:11];
                    fx2_next = (32'(s_tdata[26:19]) >= COLUMNS) ? 8'(COLUMNS - 1)
                                                                : s_tdata[26:19];
                    fy2_next = (32'(s_tdata[34:27]) >= ROWS) ? 8'(ROWS - 1)
                                                             : s_tdata[34:27];
                    lx1_next = s_tdata[10:3];
                    ly1_next = s_tdata[18:11];
                    lx2_next = s_tdata[26:19];
                    ly2_next = (s_tdata[2:0] == ACT_RECT) ? s_tdata[18:11]
                                                         : s_tdata[34:27];
                    px_next = s_tdata[10:3];
                    py_next = s_tdata[18:11];
                    case (action_t'(s_tdata[2:0]))
                        ACT_POINT: begin
                            ret_next = RET_NONE;
                            state_next = ST_RMW;
                        end
                        ACT_FILL: begin
                            state_next = ST_FILL;
                        end
                        ACT_LINE, ACT_RECT: begin
                            state_next = ST_LINE_SETUP;
                        end
                        ACT_CIRCLE: begin
                            state_next = ST_CIRCLE;
                        end
                        ACT_READ: begin
                            rd_addr = AW'(32'(s_tdata[44:43]) * COLUMNS + 32'(s_tdata[10:3]));
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_next = ((32'(xa_reg) < COLUMNS) && (32'(pg_reg) < PAGES)) ? rd_data
                                                                             : 8'h00;
                state_next = ST_OUT;
            end
            ST_FILL: begin
                if (fx_reg > fx2_reg || fy_reg > fy2_reg || xa_reg > xb_reg
                        || ya_reg > yb_reg) begin
                    state_next = ST_OUT;
                end else begin
                    px_next = fx_reg;
                    py_next = fy_reg;
                    ret_next = RET_FILL;
                    state_next = ST_RMW;
                end
            end
            ST_LINE_SETUP: begin
                dx_next = ddx;
                dy_next = ddy;
                dist_next = (ddx > ddy) ? ddx : ddy;
                sxn_next = lx2_reg < lx1_reg;
                sxz_next = lx2_reg == lx1_reg;
                syn_next = ly2_reg < ly1_reg;
                syz_next = ly2_reg == ly1_reg;
                ex_next = 10'd0;
                ey_next = 10'd0;
                cnt_next = rej ? 10'h3ff : 10'd0;
                px_next = lx1_reg;
                py_next = ly1_reg;
                state_next = ST_LINE;
            end
            ST_LINE: begin
                if (cnt_reg == 10'h3ff || cnt_reg > {1'b0, dist_reg} + 10'd1) begin
                    if (act_reg == ACT_RECT && seg_reg != 2'd3) begin
                        seg_next = seg_reg + 2'd1;
                        case (seg_reg)
                            2'd0: begin
                                lx1_next = xa_reg; ly1_next = ya_reg;
                                lx2_next = xa_reg; ly2_next = yb_reg;
                            end
                            2'd1: begin
                                lx1_next = xa_reg; ly1_next = yb_reg;
                                lx2_next = xb_reg; ly2_next = yb_reg;
                            end
                            default: begin
                                lx1_next = xb_reg; ly1_next = ya_reg;
                                lx2_next = xb_reg; ly2_next = yb_reg;
                            end
                        endcase
                        state_next = ST_LINE_SETUP;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    ret_next = RET_LINE;
                    state_next = ST_RMW;
                end
            end
            ST_CIRCLE: begin
                if ({1'b0, ca_reg} > cb_reg || cb_reg[9]) begin
                    state_next = ST_OUT;
                end else begin
                    px_next = ox;
                    py_next = oy;
                    ret_next = RET_CIRCLE;
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                wr_en = on_screen;
                case (ret_reg)
                    RET_FILL: begin
                        state_next = ST_FILL;
                        if (fy_reg == fy2_reg) begin
                            if (fx_reg == fx2_reg) begin
                                state_next = ST_OUT;
                            end else begin
                                fx_next = fx_reg + 8'd1;
                                fy_next = ya_reg;
                            end
                        end else begin
                            fy_next = fy_reg + 8'd1;
                        end
                    end
                    RET_LINE: begin
                        cnt_next = cnt_reg + 10'd1;
                        if (ex_s > {1'b0, dist_reg}) begin
                            ex_next = ex_s - {1'b0, dist_reg};
                            px_next = sxz_reg ? px_reg
                                              : (sxn_reg ? px_reg - 8'd1 : px_reg + 8'd1);
                        end else begin
                            ex_next = ex_s;
                        end
                        if (ey_s > {1'b0, dist_reg}) begin
                            ey_next = ey_s - {1'b0, dist_reg};
                            py_next = syz_reg ? py_reg
                                              : (syn_reg ? py_reg - 8'd1 : py_reg + 8'd1);
                        end else begin
                            ey_next = ey_s;
                        end
                        state_next = ST_LINE;
                    end
                    RET_CIRCLE: begin
                        oct_next = oct_reg + 3'd1;
                        if (oct_reg == 3'd7) begin
                            ca_next = ca_reg + 9'd1;
                            if (cd_reg[11]) begin
                                cd_next = cd_reg + 12'({ca_reg, 2'b00}) + 12'd10;
                            end else begin
                                cd_next = cd_reg + 12'd14 + 12'({ca_reg, 2'b00})
                                        - {cb_reg, 2'b00};
                                cb_next = cb_reg - 10'd1;
                            end
                        end
                        state_next = ST_CIRCLE;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    out_next = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            out_reg   <= 8'h00;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg <= ret_next;  res_reg <= res_next;
        act_reg <= act_next;  xa_reg <= xa_next;  ya_reg <= ya_next;
        xb_reg <= xb_next;    yb_reg <= yb_next;  pg_reg <= pg_next;
        dot_reg <= dot_next;  px_reg <= px_next;  py_reg <= py_next;
        fx2_reg <= fx2_next;  fy2_reg <= fy2_next;
        seg_reg <= seg_next;  lx1_reg <= lx1_next; ly1_reg <= ly1_next;
        lx2_reg <= lx2_next;  ly2_reg <= ly2_next;
        dx_reg <= dx_next;    dy_reg <= dy_next;  dist_reg <= dist_next;
        sxn_reg <= sxn_next;  sxz_reg <= sxz_next;
        syn_reg <= syn_next;  syz_reg <= syz_next;
        fx_reg <= fx_next;    fy_reg <= fy_next;
        ex_reg <= ex_next;    ey_reg <= ey_next;  cnt_reg <= cnt_next;
        ca_reg <= ca_next;    cb_reg <= cb_next;  cd_reg <= cd_next;
        oct_reg <= oct_next;
    end
endmodule

>>> hw/rtl/pfb_checker.sv
// Port-level checker for the page frame buffer rasterizer, bound to the top level.
// Depends on pfb_pkg and page_frame_buffer_rasterizer_defines.svh.
`include "page_frame_buffer_rasterizer_defines.svh"
module pfb_checker
    import pfb_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    `PFB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped while stalled")
    `PFB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted a word while busy")
    `PFB_ASSERT_IMPL(a_out_known, aclk, aresetn, m_tvalid, !$isunknown(m_tdata), "result word has unknown bits")
    `PFB_ASSERT_NEXT(a_no_ready_in_reset, aclk, 1'b1, !aresetn, !s_tready && !m_tvalid, "ready during reset")
endmodule

bind page_frame_buffer_rasterizer pfb_checker u_pfb_checker (.*);

>>> tb/tb_page_frame_buffer_rasterizer.sv
// Testbench for page_frame_buffer_rasterizer: drives drawing and read commands over the
// input stream and checks every result word against an in-bench pixel model or a fixed expected byte.
// Depends on pfb_pkg and the rasterizer RTL.
module tb_page_frame_buffer_rasterizer
    import pfb_pkg::*;
();

    localparam int NCOL = 128;
    localparam int NPG  = 4;
    localparam int NROW = NPG * 8;
    localparam int NUM_RANDOM = 700;

    typedef struct packed {
        logic       dot;
        logic [1:0] read_page;
        logic [7:0] radius;
        logic [7:0] y_b;
        logic [7:0] x_b;
        logic [7:0] y_a;
        logic [7:0] x_a;
        logic [2:0] action;
    } cmd_t;

    typedef struct {
        cmd_t       cmd;
        bit         fixed;
        logic [7:0] want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    logic [7:0] pixels [NPG*NCOL];
    logic [7:0] pending_bytes [$];
    row_t       rows [$];
    int         errors = 0;
    bit         stim_done;
    bit         calm;
    bit         hold_off;

    page_frame_buffer_rasterizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #400000000;
        $display("[page_frame_buffer_rasterizer] ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic void plot(input logic [7:0] x, input logic [7:0] y, input bit on);
        int idx;
        if (x >= NCOL || y >= NROW) return;
        idx = (NPG - 1 - y / 8) * NCOL + x;
        if (on) pixels[idx] |= 8'h80 >> (y % 8);
        else pixels[idx] &= ~(8'h80 >> (y % 8));
    endfunction

    function automatic void draw_line(input int x1, input int y1, input int x2,
                                      input int y2, input bit on);
        int dx, dy, sx, sy, span, ex, ey, px, py;
        if (x1 > NCOL || x2 > NCOL || y1 > NROW || y2 > NROW) return;
        dx = x2 - x1;
        dy = y2 - y1;
        sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = (dx > dy) ? dx : dy;
        px = x1;
        py = y1;
        ex = 0;
        ey = 0;
        for (int i = 0; i <= span + 1; i++) begin
            plot(px[7:0], py[7:0], on);
            ex += dx;
            ey += dy;
            if (ex > span) begin
                ex -= span;
                px += sx;
            end
            if (ey > span) begin
                ey -= span;
                py += sy;
            end
        end
    endfunction

    function automatic logic [7:0] rasterize(input cmd_t c);
        int a, b, d, x2, y2;
        logic [7:0] cx, cy, ua, ub;
        case (c.action)
            ACT_POINT: plot(c.x_a, c.y_a, c.dot);
            ACT_FILL: begin
                x2 = (c.x_b >= NCOL) ? NCOL - 1 : c.x_b;
                y2 = (c.y_b >= NROW) ? NROW - 1 : c.y_b;
                for (int x = c.x_a; x <= x2; x++)
                    for (int y = c.y_a; y <= y2; y++)
                        plot(x[7:0], y[7:0], c.dot);
            end
            ACT_LINE: draw_line(c.x_a, c.y_a, c.x_b, c.y_b, c.dot);
            ACT_RECT: begin
                draw_line(c.x_a, c.y_a, c.x_b, c.y_a, c.dot);
                draw_line(c.x_a, c.y_a, c.x_a, c.y_b, c.dot);
                draw_line(c.x_a, c.y_b, c.x_b, c.y_b, c.dot);
                draw_line(c.x_b, c.y_a, c.x_b, c.y_b, c.dot);
            end
            ACT_CIRCLE: begin
                a = 0;
                b = c.radius;
                d = 3 - 2 * b;
                cx = c.x_a;
                cy = c.y_a;
                while (a <= b) begin
                    ua = a[7:0];
                    ub = b[7:0];
                    plot(cx + ua, cy - ub, c.dot);
                    plot(cx + ub, cy - ua, c.dot);
                    plot(cx + ub, cy + ua, c.dot);
                    plot(cx + ua, cy + ub, c.dot);
                    plot(cx - ua, cy + ub, c.dot);
                    plot(cx - ub, cy + ua, c.dot);
                    plot(cx - ua, cy - ub, c.dot);
                    plot(cx - ub, cy - ua, c.dot);
                    a++;
                    if (d < 0) begin
                        d += 4 * a + 6;
                    end else begin
                        d += 10 + 4 * (a - b);
                        b--;
                    end
                end
            end
            ACT_READ: begin
                if (c.x_a < NCOL) return pixels[c.read_page * NCOL + c.x_a];
            end
            default: ;
        endcase
        return 8'h00;
    endfunction

    function automatic cmd_t mk(input action_t act, input int xa, input int ya, input int xb,
                                input int yb, input int r, input int pg, input bit on);
        cmd_t c;
        c.action = act;
        c.x_a = 8'(xa);
        c.y_a = 8'(ya);
        c.x_b = 8'(xb);
        c.y_b = 8'(yb);
        c.radius = 8'(r);
        c.read_page = 2'(pg);
        c.dot = on;
        return c;
    endfunction

    function automatic void add(input cmd_t c, input bit fixed, input logic [7:0] want);
        row_t r;
        r.cmd = c;
        r.fixed = fixed;
        r.want = want;
        rows.push_back(r);
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int sel;
        c = 46'($urandom()) ^ (46'($urandom()) << 32);
        sel = $urandom_range(0, 99);
        c.action = (sel < 25) ? ACT_READ : (sel < 45) ? ACT_POINT : (sel < 58) ? ACT_LINE :
                   (sel < 68) ? ACT_RECT : (sel < 78) ? ACT_CIRCLE : (sel < 90) ? ACT_FILL :
                   3'($urandom_range(6, 7));
        if ($urandom_range(0, 3) != 0) begin
            c.x_a = 8'($urandom_range(0, 130));
            c.x_b = 8'($urandom_range(0, 130));
            c.y_a = 8'($urandom_range(0, 34));
            c.y_b = 8'($urandom_range(0, 34));
            c.radius = 8'($urandom_range(0, 40));
        end
        if (c.action == ACT_FILL && $urandom_range(0, 1)) begin
            c.x_b = c.x_a + 8'($urandom_range(0, 12));
            c.y_b = c.y_a + 8'($urandom_range(0, 12));
        end
        return c;
    endfunction

    initial begin
        cmd_t c;
        logic [7:0] got;
        stim_done = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        add(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00);
        add(mk(ACT_READ, 127, 0, 0, 0, 0, 3, 0), 1, 8'h00);
        add(mk(ACT_POINT, 0, 0, 0, 0, 0, 0, 1), 1, 8'h00);
        add(mk(ACT_READ, 0, 0, 0, 0, 0, 3, 0), 1, 8'h80);
        add(mk(ACT_POINT, 127, 31, 0, 0, 0, 0, 1), 1, 8'h00);
        add(mk(ACT_READ, 127, 0, 0, 0, 0, 0, 0), 1, 8'h01);
        add(mk(ACT_POINT, 128, 32, 0, 0, 0, 0, 1), 1, 8'h00);
        add(mk(ACT_READ, 128, 0, 0, 0, 0, 0, 0), 1, 8'h00);
        add(mk(ACT_FILL, 0, 0, 255, 255, 0, 0, 1), 1, 8'h00);
        add(mk(ACT_READ, 64, 0, 0, 0, 0, 1, 0), 1, 8'hff);
        add(mk(ACT_FILL, 10, 10, 5, 5, 0, 0, 0), 1, 8'h00);
        add(mk(ACT_FILL, 0, 0, 255, 255, 0, 0, 0), 1, 8'h00);
        add(mk(ACT_READ, 255, 0, 0, 0, 0, 3, 0), 1, 8'h00);
        add(mk(ACT_LINE, 0, 0, 128, 32, 0, 0, 1), 0, 0);
        add(mk(ACT_LINE, 129, 0, 0, 0, 0, 0, 1), 0, 0);
        add(mk(ACT_LINE, 5, 5, 5, 5, 0, 0, 1), 0, 0);
        add(mk(ACT_RECT, 2, 3, 120, 33, 0, 0, 1), 0, 0);
        add(mk(ACT_CIRCLE, 2, 2, 0, 0, 20, 0, 1), 0, 0);
        add(mk(ACT_CIRCLE, 250, 250, 0, 0, 255, 0, 0), 0, 0);
        add(mk(ACT_CIRCLE, 64, 16, 0, 0, 0, 0, 1), 0, 0);
        add(mk(action_t'(3'd6), 1, 1, 1, 1, 1, 1, 1), 1, 8'h00);
        add(mk(action_t'(3'd7), 255, 255, 255, 255, 255, 3, 0), 1, 8'h00);
        add(mk(ACT_READ, 2, 0, 0, 0, 0, 3, 0), 0, 0);
        for (int i = 0; i < NUM_RANDOM; i++)
            add(rand_cmd(), 0, 0);
        for (int i = 0; i < NPG * NCOL; i++)
            pixels[i] = 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) begin
            c = rows[i].cmd;
            while (!calm && $urandom_range(0, 99) < 25) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {2'b00, c};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            got = rasterize(c);
            pending_bytes.push_back(rows[i].fixed ? rows[i].want : got);
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        calm = 0;
        hold_off = 0;
        wait (aresetn);
        repeat (3000) @(posedge aclk);
        hold_off = 1;
        repeat (5000) @(posedge aclk);
        hold_off = 0;
        repeat (20000) @(posedge aclk);
        calm = 1;
        repeat (30000) @(posedge aclk);
        calm = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                report("unexpected word", m_tdata, 8'h00);
            end else begin
                logic [7:0] want;
                want = pending_bytes.pop_front();
                if (m_tdata !== want) report("read_data", m_tdata, want);
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("[page_frame_buffer_rasterizer] OK");
        end else begin
            $display("[page_frame_buffer_rasterizer] ERROR");
        end
        $finish;
    end
endmodule
